>>> src/icf_pkg.sv
`default_nettype none

package icf_pkg;

  localparam int unsigned DEPTH_DEF        = 65536;
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF    = 8;

  localparam int unsigned GAIN_WIDTH      = 16;
  localparam int unsigned GAIN_FRAC       = 14;
  localparam int unsigned DELAY_WIDTH     = 24;
  localparam int unsigned BUF_LEN_WIDTH   = 17;
  localparam int unsigned MAX_DELAY_WIDTH = 24;

  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 3;

  localparam logic [BUF_LEN_WIDTH-1:0]   BUF_LEN_RST   = BUF_LEN_WIDTH'(48001);
  localparam logic [MAX_DELAY_WIDTH-1:0] MAX_DELAY_RST = MAX_DELAY_WIDTH'(12288000);

  typedef enum logic {
    REG_BUF_LEN   = 1'b0,
    REG_MAX_DELAY = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

>>> src/icf_ram.sv
`default_nettype none

module icf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> src/interpolated_comb_filter.sv
`default_nettype none

// Fractional-delay comb filter: y = a*x + b*xd + c*yd, where xd and yd are the
// input and output histories read delay_amount samples back with linear
// interpolation, and y is rounded and saturated to SAMPLE_WIDTH bits. Both
// histories live in single-port-read RAMs of DEPTH words. A new word is taken
// only after the last has left the sum state, which holds while the output
// register is stalled: each history RAM is read twice per word through its
// one read port, followed by the interpolation and gain multiply stages. A
// fill count tracks how far the histories have been written, so unwritten
// entries read as zero and the block is ready right after reset, with no
// clearing pass. Configure buf_len (0x0) and max_delay (0x4) only while idle.
module interpolated_comb_filter #(
  parameter int unsigned DEPTH        = icf_pkg::DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH = icf_pkg::SAMPLE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS    = icf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,

  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [icf_pkg::APB_ADDR_WIDTH-1:0]     paddr,
  input  wire logic [icf_pkg::APB_DATA_WIDTH-1:0]     pwdata,
  output logic      [icf_pkg::APB_DATA_WIDTH-1:0]     prdata,
  output logic                                        pready,

  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         sample_in_i,
  input  wire logic [icf_pkg::DELAY_WIDTH-1:0]        delay_amount_i,
  input  wire logic signed [icf_pkg::GAIN_WIDTH-1:0]  gain_direct_i,
  input  wire logic signed [icf_pkg::GAIN_WIDTH-1:0]  gain_forward_i,
  input  wire logic signed [icf_pkg::GAIN_WIDTH-1:0]  gain_feedback_i,

  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]              sample_out_o
);

  import icf_pkg::*;

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned FW    = (F > 0) ? F : 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = AW + 1;
  localparam int unsigned PW    = LW + F;
  localparam int unsigned PW1   = PW + 1;
  localparam int unsigned DW    = (PW > DELAY_WIDTH) ? PW : DELAY_WIDTH;
  localparam int unsigned BW    = (LW > BUF_LEN_WIDTH) ? LW : BUF_LEN_WIDTH;
  localparam int unsigned PXW   = SW + FW + 3;
  localparam int unsigned GPW   = SW + GAIN_WIDTH;
  localparam int unsigned SUMW  = GPW + 2;
  localparam int unsigned ONE   = 1 << F;
  localparam int unsigned HALF  = ONE >> 1;

  localparam logic [FW-1:0]          FMASK  = FW'(ONE - 1);
  localparam logic signed [PXW-1:0]  HALF_S = PXW'(HALF);
  localparam logic signed [SUMW-1:0] RND_S  = SUMW'(1 << (GAIN_FRAC - 1));
  localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] SAT_LO = {{(SUMW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLAMP = 8'b0000_0010,
    ST_POS   = 8'b0000_0100,
    ST_RD0   = 8'b0000_1000,
    ST_RD1   = 8'b0001_0000,
    ST_RD2   = 8'b0010_0000,
    ST_MUL   = 8'b0100_0000,
    ST_SUM   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [BUF_LEN_WIDTH-1:0]   buf_len_q;
  logic [MAX_DELAY_WIDTH-1:0] max_delay_q;
  logic [AW-1:0]              wp_q;
  logic [LW-1:0]              fill_q;
  logic                       out_valid_q;
  logic signed [SW-1:0]       sample_out_q;

  logic signed [SW-1:0]         x_q;
  logic [DELAY_WIDTH-1:0]       d_q;
  logic signed [GAIN_WIDTH-1:0] ga_q, gb_q, gc_q;
  logic [PW-1:0]                dc_q;
  logic [PW-1:0]                pos_q;
  logic [AW-1:0]                a1_q;
  logic [FW-1:0]                frac_q;
  logic                         fwd_q, hit_q;
  logic signed [SW-1:0]         ya_x_q, ya_y_q;
  logic signed [PXW-1:0]        px_q, py_q;
  logic signed [GPW-1:0]        pa_q, pb_q, pc_q;

  // config port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_BUF_LEN:   prdata = APB_DATA_WIDTH'(buf_len_q);
      REG_MAX_DELAY: prdata = APB_DATA_WIDTH'(max_delay_q);
      default:       prdata = '0;
    endcase
  end

  // effective length and span
  logic [BW-1:0] bl_w;
  logic [LW-1:0] len;
  logic [PW-1:0] span;
  assign bl_w = BW'(buf_len_q);
  always_comb begin
    if (bl_w < BW'(2)) begin
      len = LW'(2);
    end else if (bl_w > BW'(DEPTH)) begin
      len = LW'(DEPTH);
    end else begin
      len = LW'(bl_w);
    end
  end
  assign span = PW'(len) << F;

  // handshake
  logic in_acc, out_free;
  assign in_stall_o   = (state_q != ST_IDLE);
  assign in_acc       = in_valid_i && (state_q == ST_IDLE);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;

  // delay clamp
  logic [DW-1:0] c1, c2, c3;
  always_comb begin
    c1 = (DW'(d_q) > DW'(max_delay_q)) ? DW'(max_delay_q) : DW'(d_q);
    c2 = (c1 < DW'(ONE)) ? DW'(ONE) : c1;
    c3 = (c2 > DW'(span)) ? DW'(span) : c2;
  end

  // read position
  logic [PW1-1:0] pos_t;
  logic [PW-1:0]  pos_d;
  assign pos_t = (PW1'(wp_q) << F) + PW1'(span) - PW1'(dc_q);
  assign pos_d = (pos_t >= PW1'(span)) ? PW'(pos_t - PW1'(span)) : PW'(pos_t);

  // read addresses
  logic [LW-1:0] idx, a0_l;
  logic          last;
  logic [AW-1:0] a0, a1_d, raddr;
  logic [FW-1:0] frac_d;
  assign idx    = LW'(pos_q >> F);
  assign last   = idx >= (len - LW'(1));
  assign a0_l   = last ? (len - LW'(1)) : idx;
  assign a0     = a0_l[AW-1:0];
  assign a1_d   = a0 + AW'(1);
  assign frac_d = last ? '0 : (pos_q[FW-1:0] & FMASK);
  assign raddr  = (state_q == ST_RD0) ? a0 : a1_q;

  // history RAMs
  logic [SW-1:0] rd_x, rd_y;
  logic          y_we;
  logic signed [SW-1:0] y_val;

  icf_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_in_hist (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_CLAMP),
    .waddr_i (wp_q),
    .wdata_i (x_q),
    .raddr_i (raddr),
    .rdata_o (rd_x)
  );

  icf_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_out_hist (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (wp_q),
    .wdata_i (y_val),
    .raddr_i (raddr),
    .rdata_o (rd_y)
  );

  // data selection: input line forwards the current sample, unwritten entries are zero
  logic signed [SW-1:0] rsel_x, rsel_y;
  assign rsel_x = fwd_q ? x_q : (hit_q ? $signed(rd_x) : '0);
  assign rsel_y = hit_q ? $signed(rd_y) : '0;

  // interpolation
  logic signed [SW:0]    diff_x, diff_y;
  logic signed [PXW-1:0] mx, my, vx, vy;
  logic signed [GPW-1:0] pa_d, pb_d, pc_d;
  logic signed [SW-1:0]  xd, yd;
  assign diff_x = $signed({rsel_x[SW-1], rsel_x}) - $signed({ya_x_q[SW-1], ya_x_q});
  assign diff_y = $signed({rsel_y[SW-1], rsel_y}) - $signed({ya_y_q[SW-1], ya_y_q});
  assign mx     = diff_x * $signed({1'b0, frac_q});
  assign my     = diff_y * $signed({1'b0, frac_q});
  assign pa_d   = ga_q * x_q;
  assign vx     = ya_x_q + (px_q >>> F);
  assign vy     = ya_y_q + (py_q >>> F);
  assign xd     = vx[SW-1:0];
  assign yd     = vy[SW-1:0];
  assign pb_d   = gb_q * xd;
  assign pc_d   = gc_q * yd;

  // sum, round, saturate
  logic signed [SUMW-1:0] s, sh;
  assign s  = pa_q + pb_q + pc_q + RND_S;
  assign sh = s >>> GAIN_FRAC;
  always_comb begin
    if (sh > SAT_HI) begin
      y_val = SAT_HI[SW-1:0];
    end else if (sh < SAT_LO) begin
      y_val = SAT_LO[SW-1:0];
    end else begin
      y_val = sh[SW-1:0];
    end
  end

  assign y_we = (state_q == ST_SUM) && out_free;

  // write position update
  logic [LW-1:0] wp_nxt;
  assign wp_nxt = LW'(wp_q) + LW'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_POS;
      ST_POS:   state_d = ST_RD0;
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_SUM;
      ST_SUM:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      buf_len_q    <= BUF_LEN_RST;
      max_delay_q  <= MAX_DELAY_RST;
      wp_q         <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        case (reg_idx_e'(paddr[2]))
          REG_BUF_LEN:   buf_len_q   <= pwdata[BUF_LEN_WIDTH-1:0];
          REG_MAX_DELAY: max_delay_q <= pwdata[MAX_DELAY_WIDTH-1:0];
          default:       ;
        endcase
      end
      if (in_acc && (LW'(wp_q) >= len)) begin
        wp_q <= '0;
      end
      if (y_we) begin
        wp_q <= (wp_nxt >= len) ? '0 : wp_nxt[AW-1:0];
        if (wp_nxt > fill_q) begin
          fill_q <= wp_nxt;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q  <= sample_in_i;
      d_q  <= delay_amount_i;
      ga_q <= gain_direct_i;
      gb_q <= gain_forward_i;
      gc_q <= gain_feedback_i;
    end
    if (state_q == ST_CLAMP) begin
      dc_q <= PW'(c3);
    end
    if (state_q == ST_POS) begin
      pos_q <= pos_d;
    end
    if (state_q == ST_RD0) begin
      a1_q   <= a1_d;
      frac_q <= frac_d;
    end
    fwd_q <= (raddr == wp_q);
    hit_q <= (LW'(raddr) < fill_q);
    if (state_q == ST_RD1) begin
      ya_x_q <= rsel_x;
      ya_y_q <= rsel_y;
    end
    if (state_q == ST_RD2) begin
      px_q <= mx + HALF_S;
      py_q <= my + HALF_S;
      pa_q <= pa_d;
    end
    if (state_q == ST_MUL) begin
      pb_q <= pb_d;
      pc_q <= pc_d;
    end
    if (y_we) begin
      sample_out_q <= y_val;
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_interpolated_comb_filter.sv
`timescale 1ns / 100ps

module tb_interpolated_comb_filter;
  import icf_pkg::*;

  localparam int unsigned DEPTH    = DEPTH_DEF;
  localparam int unsigned SAMPLE_W = SAMPLE_WIDTH_DEF;
  localparam int unsigned FRAC     = FRAC_BITS_DEF;
  localparam longint      SAT_HI   = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint      SAT_LO   = -SAT_HI - 1;
  localparam int          LIMIT    = 500000;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    reg_idx_e                  idx;
    logic [31:0]               val;
    logic signed [23:0]        x;
    logic [DELAY_WIDTH-1:0]    d;
    logic signed [15:0]        a;
    logic signed [15:0]        b;
    logic signed [15:0]        c;
    logic                      has_exp;
    logic signed [23:0]        exp_y;
  } row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [APB_ADDR_WIDTH-1:0]         paddr;
  logic [APB_DATA_WIDTH-1:0]         pwdata;
  logic [APB_DATA_WIDTH-1:0]         prdata;
  logic                              pready;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic signed [SAMPLE_W-1:0]        sample_in_i;
  logic [DELAY_WIDTH-1:0]            delay_amount_i;
  logic signed [GAIN_WIDTH-1:0]      gain_direct_i;
  logic signed [GAIN_WIDTH-1:0]      gain_forward_i;
  logic signed [GAIN_WIDTH-1:0]      gain_feedback_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [SAMPLE_W-1:0]        sample_out_o;

  // predictor state
  int                     in_hist [DEPTH];
  int                     out_hist [DEPTH];
  int unsigned            wr_pos;
  logic [BUF_LEN_WIDTH-1:0]   buf_len_q;
  logic [MAX_DELAY_WIDTH-1:0] max_delay_q;

  logic signed [SAMPLE_W-1:0] pending_out [$];
  int words_in;
  int words_out;
  int err_cnt;

  interpolated_comb_filter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_in_i     (sample_in_i),
    .delay_amount_i  (delay_amount_i),
    .gain_direct_i   (gain_direct_i),
    .gain_forward_i  (gain_forward_i),
    .gain_feedback_i (gain_feedback_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_o    (sample_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cyc;
    for (cyc = 0; cyc < LIMIT; cyc++) @(posedge clk_i);
    $display("interpolated_comb_filter: mismatch");
    $finish;
  end

  function automatic row_t w_row(input int x, input int d, input int a, input int b,
                                 input int c, input bit has, input int y);
    row_t r;
    r         = '0;
    r.kind    = ROW_WORD;
    r.x       = 24'(x);
    r.d       = 24'(d);
    r.a       = 16'(a);
    r.b       = 16'(b);
    r.c       = 16'(c);
    r.has_exp = has;
    r.exp_y   = 24'(y);
    return r;
  endfunction

  function automatic row_t r_row(input reg_idx_e idx, input int val);
    row_t r;
    r      = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.val  = 32'(val);
    return r;
  endfunction

  function automatic longint history_tap(input bit from_out, input int unsigned len,
                                         input longint rpos);
    int unsigned i;
    longint      f;
    longint      lo;
    longint      hi;
    i = 32'(rpos >> FRAC);
    f = rpos & ((longint'(1) << FRAC) - 1);
    if (i >= len - 1) begin
      return from_out ? longint'(out_hist[len-1]) : longint'(in_hist[len-1]);
    end
    lo = from_out ? longint'(out_hist[i])   : longint'(in_hist[i]);
    hi = from_out ? longint'(out_hist[i+1]) : longint'(in_hist[i+1]);
    return lo + (((hi - lo) * f + (longint'(1) << (FRAC - 1))) >>> FRAC);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] filter_sample(input row_t r);
    int unsigned len;
    longint      x;
    longint      dly;
    longint      span;
    longint      rpos;
    longint      xd;
    longint      yd;
    longint      acc;
    longint      y;
    len = buf_len_q;
    if (len < 2) len = 2;
    if (len > DEPTH) len = DEPTH;
    if (wr_pos >= len) wr_pos = 0;
    x = r.x;
    in_hist[wr_pos] = int'(x);
    span = longint'(len) << FRAC;
    dly  = longint'(r.d);
    if (dly > longint'(max_delay_q)) dly = longint'(max_delay_q);
    if (dly < (longint'(1) << FRAC)) dly = longint'(1) << FRAC;
    if (dly > span) dly = span;
    rpos = (longint'(wr_pos) << FRAC) + span - dly;
    if (rpos >= span) rpos = rpos - span;
    xd  = history_tap(1'b0, len, rpos);
    yd  = history_tap(1'b1, len, rpos);
    acc = longint'(r.a) * x + longint'(r.b) * xd + longint'(r.c) * yd;
    y   = (acc + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    if (y > SAT_HI) y = SAT_HI;
    if (y < SAT_LO) y = SAT_LO;
    out_hist[wr_pos] = int'(y);
    wr_pos++;
    if (wr_pos >= len) wr_pos = 0;
    return SAMPLE_W'(y);
  endfunction

  task automatic offer_word(input row_t r);
    logic signed [SAMPLE_W-1:0] y;
    while ((words_in < 400 || words_in >= 600) && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_in_i     <= r.x;
    delay_amount_i  <= r.d;
    gain_direct_i   <= r.a;
    gain_forward_i  <= r.b;
    gain_feedback_i <= r.c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    y = filter_sample(r);
    pending_out.push_back(r.has_exp ? r.exp_y : y);
    words_in++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BUF_LEN) buf_len_q = val[BUF_LEN_WIDTH-1:0];
    else max_delay_q = val[MAX_DELAY_WIDTH-1:0];
  endtask

  // output side: check, random stall, one long hold-off
  initial begin : out_side
    int                         hold_left;
    bit                         held;
    logic signed [SAMPLE_W-1:0] want;
    hold_left   = 0;
    held        = 1'b0;
    out_stall_i = 1'b0;
    words_out   = 0;
    err_cnt     = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_out.size() == 0) begin
          err_cnt++;
          $error("sample_out: expected none, got %0d", sample_out_o);
        end else begin
          want = pending_out.pop_front();
          if (sample_out_o !== want) begin
            err_cnt++;
            $error("sample_out: expected %0d, got %0d", want, sample_out_o);
          end
        end
        words_out++;
      end
      if (!held && words_out >= 900) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (words_out < 400 || words_out >= 600) && ($urandom_range(99) < 18);
      end
    end
  end

  initial begin : main
    row_t        dir_rows [$];
    row_t        r;
    int          phase;
    int          k;
    int          sel;
    int unsigned blen;
    int unsigned mdly;
    int unsigned len_eff;
    int unsigned dhi;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    sample_in_i     = '0;
    delay_amount_i  = '0;
    gain_direct_i   = '0;
    gain_forward_i  = '0;
    gain_feedback_i = '0;
    wr_pos          = 0;
    buf_len_q       = BUF_LEN_RST;
    max_delay_q     = MAX_DELAY_RST;
    words_in        = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      w_row( 8388607,   256,  16384,      0,      0, 1,  8388607),
      w_row(-8388608,   256,  16384,      0,      0, 1, -8388608),
      w_row( 8388607,   256,  32767,      0,      0, 1,  8388607),
      w_row( 8388607,   256, -32768,      0,      0, 1, -8388608),
      w_row(-8388608,   256, -32768,      0,      0, 1,  8388607),
      w_row(       0,     0,      0,  16384,      0, 1, -8388608),
      w_row( 1234567,     0,      0,      0,  16384, 0, 0),
      w_row(-4000000,   384,   8192,   8192,      0, 0, 0),
      w_row( 3000000, 16777215, 16384, -32768, 32767, 0, 0),
      w_row(      -1, 12287999,    -1,  32767, -32768, 0, 0),
      w_row( 5555555,  1791, -16384,  16383, -16383, 0, 0),
      r_row(REG_BUF_LEN, 2),
      r_row(REG_MAX_DELAY, 16777215),
      // delay clamps to the whole line: reads the word just written
      w_row( 8388607, 16777215,     0,  16384,      0, 1,  8388607),
      w_row(-8388608,   384,      0,  16384,  16384, 0, 0),
      w_row(      77,   256,  16384, -16384,  16384, 0, 0),
      r_row(REG_BUF_LEN, 1),
      r_row(REG_MAX_DELAY, 0),
      w_row(     -77,  5000,  16384,  16384,  16384, 0, 0),
      r_row(REG_MAX_DELAY, 255),
      w_row( 4194304,     0,   8192,   8192,   8192, 0, 0),
      r_row(REG_BUF_LEN, 0),
      w_row(-4194304,   640,  16384,  16384, -16384, 0, 0),
      r_row(REG_BUF_LEN, 131071),
      r_row(REG_MAX_DELAY, 16776960),
      w_row( 8388607, 16777215, 16384,  16384,      0, 0, 0),
      w_row(-8388608, 16776960, 16384,  16384,  16384, 0, 0),
      w_row( 2796202, 12345678, 10923, -10923,   5461, 0, 0),
      r_row(REG_BUF_LEN, 16),
      r_row(REG_MAX_DELAY, 256),
      w_row(-2796203, 16777215, 16384,  16384,  16384, 0, 0),
      w_row(  100000,     0,  16384, -16384,   8192, 0, 0),
      r_row(REG_BUF_LEN, 65536),
      r_row(REG_MAX_DELAY, 12288000),
      w_row( -100000,  4095,  16384,  16384,  16384, 0, 0)
    };

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain();
        reg_write(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        offer_word(dir_rows[i]);
      end
    end

    for (phase = 0; phase < 16; phase++) begin
      drain();
      sel = $urandom_range(9);
      case (sel)
        0:       blen = $urandom_range(1);
        1:       blen = $urandom_range(131071, 65536);
        2:       blen = $urandom_range(65536, 301);
        default: blen = $urandom_range(300, 2);
      endcase
      len_eff = (blen < 2) ? 2 : (blen > DEPTH) ? DEPTH : blen;
      sel = $urandom_range(9);
      case (sel)
        0:       mdly = $urandom_range(255);
        1:       mdly = $urandom & 32'h00FF_FFFF;
        2:       mdly = $urandom_range(1) ? 16776960 : 16777215;
        default: begin
          dhi  = len_eff * 256 + 255;
          if (dhi > 16777215) dhi = 16777215;
          mdly = $urandom_range(dhi, 256);
        end
      endcase
      reg_write(REG_BUF_LEN, blen);
      reg_write(REG_MAX_DELAY, mdly);
      dhi = ((mdly < len_eff * 256) ? mdly : len_eff * 256) + 300;
      if (dhi > 16777215) dhi = 16777215;
      for (k = 0; k < 100; k++) begin
        r      = '0;
        r.kind = ROW_WORD;
        r.x    = 24'($urandom);
        if ($urandom_range(4) == 0) r.d = 24'($urandom);
        else r.d = 24'($urandom_range(dhi));
        if ($urandom_range(3) == 0) begin
          r.a = 16'($urandom);
          r.b = 16'($urandom);
          r.c = 16'($urandom);
        end else begin
          r.a = 16'($urandom_range(32768) - 16384);
          r.b = 16'($urandom_range(32768) - 16384);
          r.c = 16'($urandom_range(24000) - 12000);
        end
        offer_word(r);
      end
    end

    drain();
    repeat (32) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("interpolated_comb_filter: match");
    end else begin
      $display("interpolated_comb_filter: mismatch");
    end
    $finish;
  end

endmodule
